>>> design/lrux_pkg.sv
// ----------------------------------------------------------------------------
// lrux_pkg: shared definitions of the LRU cache with expiry
// Operation, status and register codes, default sizes and bus widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lrux_pkg;

   localparam int CAPACITY_DEFAULT  = 64;
   localparam int KEY_WIDTH_DEFAULT = 64;

   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 160;

   // request operations
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_PUT   = 3'd1;
   localparam logic [2:0] OP_GET   = 3'd2;
   localparam logic [2:0] OP_EVICT = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // response status
   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_INS_EVICT = 3'd3;
   localparam logic [2:0] ST_HIT       = 3'd4;
   localparam logic [2:0] ST_MISS      = 3'd5;
   localparam logic [2:0] ST_EXPIRED   = 3'd6;

   // configuration registers
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_TTL      = 1'b1;

   localparam logic [6:0]  CAP_RESET = 7'd64;
   localparam logic [31:0] TTL_RESET = 32'd3600;

endpackage

`default_nettype wire

>>> design/lru_cache_with_expiry.sv
// ----------------------------------------------------------------------------
// lru_cache_with_expiry: fully associative LRU table with time-to-live
// Sweep-based lookup, recency update and expiry over a tag RAM.
// ----------------------------------------------------------------------------
// One request is in work at a time; the next is taken as soon as the previous
// result sits in the output register. Tick, clear and unknown operations go
// straight to the response. Put and get take one lookup sweep of the tag RAM,
// a decision step and, for an update or a hit, a payload read and write, then
// one recency sweep; a get miss ends after the lookup. Evict-expired runs one
// lookup sweep, a decision step and one recency sweep per stale entry, then a
// final lookup. The tag RAM has a single read port: every sweep visits each
// entry once. No clearing pass is needed after reset; valid bits live in
// flip-flops.
`default_nettype none

module lru_cache_with_expiry #(
   parameter int CAPACITY  = lrux_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = lrux_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: tdata = key_tag[63:0], response_handle[95:64], category_id[111:96]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [lrux_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser = operation[2:0]
   input  wire logic [2:0]                       req_tuser,
   // response: tdata = out_response[31:0], out_category[47:32], out_hits[79:48],
   // evicted_tag[143:80], removed_count[150:144], entry_count[157:151], zero pad
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [lrux_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser = status[2:0]
   output logic      [2:0]                       rsp_tuser,
   // configuration write
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic                             csr_index,
   input  wire logic [31:0]                      csr_data
);

   import lrux_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int TAG_W = KEY_WIDTH + 32 + IDX_W;
   localparam int PAY_W = 80;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_PREAD, S_PDATA, S_PASS, S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PM_FRONT, PM_DROP, PM_INSERT
   } pass_type;

   state_type state_ff;
   pass_type  mode_ff;

   // request under work
   logic [2:0]           op_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [31:0]          resp_ff;
   logic [15:0]          cat_ff;

   // table state
   logic [CAPACITY-1:0]  valid_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [31:0]          time_ff;
   logic [6:0]           cap_ff;
   logic [31:0]          ttl_ff;

   // sweep engine
   logic [CNT_W-1:0]     cnt_ff;
   logic                 pv_ff;
   logic [IDX_W-1:0]     pi_ff;

   // lookup results
   logic                 fnd_ff;
   logic [IDX_W-1:0]     fnd_idx_ff;
   logic [IDX_W-1:0]     fnd_rank_ff;
   logic [31:0]          fnd_stamp_ff;
   logic                 lru_ff;
   logic [IDX_W-1:0]     lru_idx_ff;
   logic [IDX_W-1:0]     lru_rank_ff;
   logic [KEY_WIDTH-1:0] lru_key_ff;
   logic                 free_ff;
   logic [IDX_W-1:0]     free_idx_ff;

   // recency pass control
   logic [IDX_W-1:0]     pidx_ff;
   logic [IDX_W-1:0]     prank_ff;
   logic                 drop_en_ff;

   // result under construction
   logic [2:0]           status_ff;
   logic [31:0]          o_resp_ff;
   logic [15:0]          o_cat_ff;
   logic [31:0]          o_hits_ff;
   logic [63:0]          evicted_ff;
   logic [CNT_W-1:0]     removed_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;
   logic [2:0]               rsp_user_ff;

   // RAM ports
   logic                 tag_we;
   logic [IDX_W-1:0]     tag_waddr;
   logic [TAG_W-1:0]     tag_wdata;
   logic                 tag_re;
   logic [IDX_W-1:0]     tag_raddr;
   logic [TAG_W-1:0]     tag_rdata;
   logic                 pay_we;
   logic [IDX_W-1:0]     pay_waddr;
   logic [PAY_W-1:0]     pay_wdata;
   logic                 pay_re;
   logic [PAY_W-1:0]     pay_rdata;

   // decoded sweep data
   logic [KEY_WIDTH-1:0] td_key;
   logic [31:0]          td_stamp;
   logic [IDX_W-1:0]     td_rank;
   logic                 pvalid;
   logic                 td_stale;
   logic                 td_match;
   logic                 sweep_issue;
   logic                 sweep_done;
   logic [KEY_WIDTH-1:0] new_key;
   logic [31:0]          new_stamp;
   logic [IDX_W-1:0]     new_rank;

   // decision helpers
   logic [CMP_W-1:0]     cap_eff;
   logic                 put_evict;
   logic                 put_ins;
   logic [IDX_W-1:0]     put_target;
   logic                 fnd_stale;
   logic [31:0]          hits_inc;

   lrux_ram #(.WIDTH(TAG_W), .DEPTH(CAPACITY)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_en   (tag_re),
      .rd_addr (tag_raddr),
      .rd_data (tag_rdata)
   );

   lrux_ram #(.WIDTH(PAY_W), .DEPTH(CAPACITY)) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (pay_wdata),
      .rd_en   (pay_re),
      .rd_addr (fnd_idx_ff),
      .rd_data (pay_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // tag word: key, stamp, rank from the top down
   assign td_key   = tag_rdata[TAG_W-1 -: KEY_WIDTH];
   assign td_stamp = tag_rdata[IDX_W +: 32];
   assign td_rank  = tag_rdata[IDX_W-1:0];
   assign pvalid   = valid_ff[pi_ff];
   assign td_stale = (time_ff - td_stamp) > ttl_ff;
   assign td_match = (op_ff == OP_EVICT) ? (pvalid && td_stale)
                                         : (pvalid && (td_key == key_ff));

   // issue one read per cycle, process it in the next cycle, write back behind
   assign sweep_issue = ((state_ff == S_SCAN) || (state_ff == S_PASS))
                        && (cnt_ff != CNT_W'(CAPACITY));
   assign sweep_done  = (cnt_ff == CNT_W'(CAPACITY)) && !pv_ff;
   assign tag_re      = sweep_issue;
   assign tag_raddr   = cnt_ff[IDX_W-1:0];
   assign tag_we      = (state_ff == S_PASS) && pv_ff && pvalid;
   assign tag_waddr   = pi_ff;
   assign tag_wdata   = {new_key, new_stamp, new_rank};

   // rank adjustment of the entry under the write-back stage
   always_comb begin
      new_key   = td_key;
      new_stamp = td_stamp;
      new_rank  = td_rank;
      case (mode_ff)
         PM_FRONT: begin
            if (pi_ff == pidx_ff) begin
               new_rank = '0;
               if (op_ff == OP_PUT) begin
                  new_stamp = time_ff;
               end
            end else if (td_rank < prank_ff) begin
               new_rank = td_rank + IDX_W'(1);
            end
         end
         PM_DROP: begin
            if (td_rank > prank_ff) begin
               new_rank = td_rank - IDX_W'(1);
            end
         end
         PM_INSERT: begin
            if (pi_ff == pidx_ff) begin
               new_key   = key_ff;
               new_stamp = time_ff;
               new_rank  = '0;
            end else if (drop_en_ff && (td_rank > prank_ff)) begin
               new_rank = td_rank;
            end else begin
               new_rank = td_rank + IDX_W'(1);
            end
         end
         default: begin
            new_rank = td_rank;
         end
      endcase
   end

   // effective capacity: zero acts as one, above the table size acts as full
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == 7'd0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(CAPACITY)) begin
         cap_eff = CMP_W'(CAPACITY);
      end
   end

   assign put_evict  = (CMP_W'(count_ff) >= cap_eff) && lru_ff;
   assign put_ins    = put_evict || free_ff;
   assign put_target = (put_evict && !(free_ff && (free_idx_ff < lru_idx_ff)))
                       ? lru_idx_ff : free_idx_ff;
   assign fnd_stale  = (time_ff - fnd_stamp_ff) > ttl_ff;
   assign hits_inc   = (pay_rdata[31:0] == 32'hFFFF_FFFF) ? pay_rdata[31:0]
                                                          : pay_rdata[31:0] + 32'd1;

   // payload word: response, category, hits from the top down
   always_comb begin
      pay_re    = (state_ff == S_PREAD);
      pay_we    = 1'b0;
      pay_waddr = fnd_idx_ff;
      pay_wdata = {resp_ff, cat_ff, 32'd0};
      if ((state_ff == S_DECIDE) && (op_ff == OP_PUT) && !fnd_ff && put_ins) begin
         pay_we    = 1'b1;
         pay_waddr = put_target;
      end else if (state_ff == S_PDATA) begin
         pay_we = 1'b1;
         if (op_ff == OP_PUT) begin
            pay_wdata = {resp_ff, pay_rdata[47:32], pay_rdata[31:0]};
         end else begin
            pay_wdata = {pay_rdata[79:48], pay_rdata[47:32], hits_inc};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         cap_ff       <= CAP_RESET;
         ttl_ff       <= TTL_RESET;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         // configuration, taken at any time
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CAPACITY: cap_ff <= csr_data[6:0];
               CSR_TTL:      ttl_ff <= csr_data;
               default:      ttl_ff <= ttl_ff;
            endcase
         end

         // drop the response once taken
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // advance the sweep pipeline
         if (sweep_issue) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         pv_ff <= sweep_issue;
         pi_ff <= cnt_ff[IDX_W-1:0];

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff      <= req_tuser;
                  key_ff     <= req_tdata[KEY_WIDTH-1:0];
                  resp_ff    <= req_tdata[95:64];
                  cat_ff     <= req_tdata[111:96];
                  status_ff  <= ST_DONE;
                  o_resp_ff  <= '0;
                  o_cat_ff   <= '0;
                  o_hits_ff  <= '0;
                  evicted_ff <= '0;
                  removed_ff <= '0;
                  fnd_ff     <= 1'b0;
                  lru_ff     <= 1'b0;
                  free_ff    <= 1'b0;
                  cnt_ff     <= '0;
                  unique case (req_tuser)
                     OP_TICK: begin
                        if (time_ff != 32'hFFFF_FFFF) begin
                           time_ff <= time_ff + 32'd1;
                        end
                        state_ff <= S_RESP;
                     end
                     OP_PUT, OP_GET, OP_EVICT: begin
                        state_ff <= S_SCAN;
                     end
                     OP_CLEAR: begin
                        removed_ff <= count_ff;
                        valid_ff   <= '0;
                        count_ff   <= '0;
                        state_ff   <= S_RESP;
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end

            S_SCAN: begin
               if (pv_ff) begin
                  if (td_match && !fnd_ff) begin
                     fnd_ff       <= 1'b1;
                     fnd_idx_ff   <= pi_ff;
                     fnd_rank_ff  <= td_rank;
                     fnd_stamp_ff <= td_stamp;
                  end
                  if (pvalid && (!lru_ff || (td_rank > lru_rank_ff))) begin
                     lru_ff      <= 1'b1;
                     lru_idx_ff  <= pi_ff;
                     lru_rank_ff <= td_rank;
                     lru_key_ff  <= td_key;
                  end
                  if (!pvalid && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= pi_ff;
                  end
               end
               if (sweep_done) begin
                  state_ff <= S_DECIDE;
               end
            end

            S_DECIDE: begin
               cnt_ff   <= '0;
               state_ff <= S_PASS;
               case (op_ff)
                  OP_PUT: begin
                     if (fnd_ff) begin
                        status_ff <= ST_UPDATED;
                        mode_ff   <= PM_FRONT;
                        pidx_ff   <= fnd_idx_ff;
                        prank_ff  <= fnd_rank_ff;
                        state_ff  <= S_PREAD;
                     end else begin
                        status_ff  <= put_evict ? ST_INS_EVICT : ST_INSERTED;
                        evicted_ff <= put_evict ? 64'(lru_key_ff) : 64'd0;
                        mode_ff    <= PM_INSERT;
                        drop_en_ff <= put_evict;
                        prank_ff   <= lru_rank_ff;
                        pidx_ff    <= put_target;
                        if (put_evict) begin
                           valid_ff[lru_idx_ff] <= 1'b0;
                        end
                        if (put_ins) begin
                           valid_ff[put_target] <= 1'b1;
                           if (!put_evict) begin
                              count_ff <= count_ff + CNT_W'(1);
                           end
                        end else begin
                           state_ff <= S_RESP;
                        end
                     end
                  end
                  OP_GET: begin
                     if (!fnd_ff) begin
                        status_ff <= ST_MISS;
                        state_ff  <= S_RESP;
                     end else if (fnd_stale) begin
                        status_ff            <= ST_EXPIRED;
                        valid_ff[fnd_idx_ff] <= 1'b0;
                        count_ff             <= count_ff - CNT_W'(1);
                        mode_ff              <= PM_DROP;
                        prank_ff             <= fnd_rank_ff;
                     end else begin
                        status_ff <= ST_HIT;
                        mode_ff   <= PM_FRONT;
                        pidx_ff   <= fnd_idx_ff;
                        prank_ff  <= fnd_rank_ff;
                        state_ff  <= S_PREAD;
                     end
                  end
                  default: begin
                     // evict expired: drop the first stale entry, then rescan
                     if (fnd_ff) begin
                        valid_ff[fnd_idx_ff] <= 1'b0;
                        count_ff             <= count_ff - CNT_W'(1);
                        removed_ff           <= removed_ff + CNT_W'(1);
                        mode_ff              <= PM_DROP;
                        prank_ff             <= fnd_rank_ff;
                     end else begin
                        state_ff <= S_RESP;
                     end
                  end
               endcase
            end

            S_PREAD: begin
               state_ff <= S_PDATA;
            end

            S_PDATA: begin
               if (op_ff == OP_GET) begin
                  o_resp_ff <= pay_rdata[79:48];
                  o_cat_ff  <= pay_rdata[47:32];
                  o_hits_ff <= hits_inc;
               end
               cnt_ff   <= '0;
               state_ff <= S_PASS;
            end

            S_PASS: begin
               if (sweep_done) begin
                  if (op_ff == OP_EVICT) begin
                     fnd_ff   <= 1'b0;
                     lru_ff   <= 1'b0;
                     free_ff  <= 1'b0;
                     cnt_ff   <= '0;
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_RESP;
                  end
               end
            end

            S_RESP: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= status_ff;
                  rsp_data_ff  <= {2'b00, 7'(count_ff), 7'(removed_ff), evicted_ff,
                                   o_hits_ff, o_cat_ff, o_resp_ff};
                  state_ff     <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/lrux_ram.sv
// ----------------------------------------------------------------------------
// lrux_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrux_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/lrux_checker.sv
// ----------------------------------------------------------------------------
// lrux_checker: port-level checks of the LRU cache with expiry
// Watches the response channel and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrux_checker #(
   parameter int CAPACITY = lrux_pkg::CAPACITY_DEFAULT
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [lrux_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [2:0]                       rsp_tuser
);

   import lrux_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // entry count never exceeds the table size
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[157:151] <= 7'(CAPACITY)))
      else $error("entry count above capacity");

   // only put with eviction reports an evicted key
   a_evict_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_INS_EVICT) |-> (rsp_tdata[143:80] == 64'd0))
      else $error("evicted key outside of eviction");

   // only a hit carries entry values
   a_hit_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_HIT) |-> (rsp_tdata[79:0] == 80'd0))
      else $error("entry values on a non-hit response");

endmodule

bind lru_cache_with_expiry lrux_checker #(.CAPACITY(CAPACITY)) u_lrux_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
